>>> src/mfcs_pkg.sv
package mfcs_pkg;

  // Default graph size; the top level can override it.
  localparam int MAX_VERTICES_DEF = 16;

  // Fixed field widths of the request and result channels.
  localparam int MODE_W      = 2;
  localparam int VERT_W      = 4;
  localparam int FRONTIER_W  = 8;
  localparam int SIZE_W      = 5;
  localparam int MEMBERS_W   = 16;
  localparam int VCOUNT_W    = 5;

  // Vertex count after reset.
  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 5'd16;

  // Request modes. The fourth code is ignored.
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADD   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RUN   = 2'd2;

endpackage

>>> src/mfcs_in_if.sv
interface mfcs_in_if;
  logic                          valid;
  logic                          ready;
  logic [mfcs_pkg::MODE_W-1:0]   mode;
  logic [mfcs_pkg::VERT_W-1:0]   vertex_a;
  logic [mfcs_pkg::VERT_W-1:0]   vertex_b;

  modport source (output valid, output mode, output vertex_a, output vertex_b, input ready);
  modport sink   (input valid, input mode, input vertex_a, input vertex_b, output ready);
endinterface

>>> src/mfcs_out_if.sv
interface mfcs_out_if;
  logic                              valid;
  logic                              ready;
  logic [mfcs_pkg::FRONTIER_W-1:0]   best_frontier;
  logic [mfcs_pkg::SIZE_W-1:0]       best_size;
  logic [mfcs_pkg::MEMBERS_W-1:0]    best_members;

  modport source (output valid, output best_frontier, output best_size,
                  output best_members, input ready);
  modport sink   (input valid, input best_frontier, input best_size,
                  input best_members, output ready);
endinterface

>>> src/mfcs_eval.sv
// Checks one candidate vertex set against the adjacency store and registers
// its frontier when the set is a clique of a size that the search counts.
module mfcs_eval #(
  parameter int MAX_VERTICES = mfcs_pkg::MAX_VERTICES_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      en,
  input  logic [$clog2(MAX_VERTICES+1)-1:0]         n,
  input  logic [MAX_VERTICES-1:0]                   mask,
  input  logic [MAX_VERTICES-1:0][MAX_VERTICES-1:0] rows,
  input  logic [$clog2(MAX_VERTICES*(MAX_VERTICES-1)+1)-1:0] dsum,
  input  logic [$clog2(MAX_VERTICES*(MAX_VERTICES-1)+1)-1:0] kk,
  input  logic [$clog2(MAX_VERTICES+1)-1:0]         pop,
  output logic                                      ev_valid_r,
  output logic [$clog2(MAX_VERTICES*(MAX_VERTICES-1)+1)-1:0] ev_f_r,
  output logic [$clog2(MAX_VERTICES+1)-1:0]         ev_k_r,
  output logic [MAX_VERTICES-1:0]                   ev_m_r
);

  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  logic is_clique;
  logic size_ok;
  logic ev_valid_nxt;

  // Every member must be linked to every other member of the set.
  always_comb begin
    is_clique = 1'b1;
    for (int v = 0; v < MAX_VERTICES; v++) begin
      if (mask[v] && |(mask & ~rows[v] & ~(MAX_VERTICES'(1) << v))) begin
        is_clique = 1'b0;
      end
    end
  end

  // Only sizes from two up to one below the vertex count are searched.
  assign size_ok      = (pop >= CNT_W'(2)) && (pop < n);
  assign ev_valid_nxt = en && is_clique && size_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_valid_r <= 1'b0;
    end else begin
      ev_valid_r <= ev_valid_nxt;
    end
  end

  // In a clique every member's degree is at least size minus one, so the
  // difference never wraps.
  always_ff @(posedge clk) begin
    if (ev_valid_nxt) begin
      ev_f_r <= dsum - kk;
      ev_k_r <= pop;
      ev_m_r <= mask;
    end
  end

endmodule

>>> src/max_frontier_clique_search.sv
// Edge and clear requests are accepted back to back. A search request (n is the
// vertex count in use) runs degree counting over the n vertices, then a Gray-code
// walk over the vertex subsets, one subset per cycle, then a drain and a load state;
// the load waits while an earlier result is not taken, and the next request is
// taken after the load.
// Reset (rst_n, synchronous, active low) empties the graph and sets the count to 16.
module max_frontier_clique_search #(
  parameter int MAX_VERTICES = mfcs_pkg::MAX_VERTICES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  mfcs_in_if.sink                         in_ch,
  mfcs_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [mfcs_pkg::VCOUNT_W-1:0]   cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int DEG_W = $clog2(MAX_VERTICES);
  localparam int SUM_W = $clog2(MAX_VERTICES * (MAX_VERTICES - 1) + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DEG   = 5'b00010,
    S_SCAN  = 5'b00100,
    S_DRAIN = 5'b01000,
    S_FINAL = 5'b10000
  } state_t;

  state_t                                 state_r, state_nxt;
  logic [mfcs_pkg::VCOUNT_W-1:0]          vcount_r;
  logic [MAX_VERTICES-1:0][MAX_VERTICES-1:0] rows_r;
  logic [MAX_VERTICES-1:0][MAX_VERTICES-1:0] rows_add;
  logic [DEG_W-1:0]                       deg_r [MAX_VERTICES];
  logic [CNT_W-1:0]                       n_r;
  logic [IDX_W-1:0]                       d_idx_r;
  logic [DEG_W-1:0]                       top_deg_r;
  logic [IDX_W-1:0]                       top_node_r;
  logic [MAX_VERTICES-1:0]                cnt_r;
  logic [MAX_VERTICES-1:0]                gmask_r;
  logic [SUM_W-1:0]                       dsum_r;
  logic [SUM_W-1:0]                       kk_r;
  logic [CNT_W-1:0]                       pop_r;
  logic [SUM_W-1:0]                       best_f_r;
  logic [CNT_W-1:0]                       best_k_r;
  logic [MAX_VERTICES-1:0]                best_m_r;
  logic                                   out_valid_r;
  logic [mfcs_pkg::FRONTIER_W-1:0]        out_f_r;
  logic [mfcs_pkg::SIZE_W-1:0]            out_k_r;
  logic [mfcs_pkg::MEMBERS_W-1:0]         out_m_r;

  logic                                   in_acc;
  logic                                   run_acc;
  logic                                   add_ok;
  logic [CNT_W-1:0]                       n_sel;
  logic [MAX_VERTICES-1:0]                nmask;
  logic [DEG_W-1:0]                       deg_c;
  logic                                   deg_last;
  logic [MAX_VERTICES-1:0]                cnt_inc;
  logic [IDX_W-1:0]                       flip_b;
  logic                                   flip_on;
  logic [DEG_W-1:0]                       deg_f;
  logic                                   scan_last;
  logic                                   ev_valid;
  logic [SUM_W-1:0]                       ev_f;
  logic [CNT_W-1:0]                       ev_k;
  logic [MAX_VERTICES-1:0]                ev_m;
  logic [MAX_VERTICES-1:0]                ev_rev;
  logic [MAX_VERTICES-1:0]                best_rev;
  logic                                   better;
  logic                                   use_top;
  logic                                   out_load;
  logic [31:0]                            top_mask32;
  logic [31:0]                            best_mask32;

  // Request handshake: the block takes requests whenever no search is running.
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign run_acc     = in_acc && (in_ch.mode == mfcs_pkg::MODE_RUN);
  assign add_ok      = (32'(in_ch.vertex_a) < MAX_VERTICES) &&
                       (32'(in_ch.vertex_b) < MAX_VERTICES);

  // Vertex count in use, limited to the store size.
  assign n_sel = (32'(vcount_r) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES) : CNT_W'(vcount_r);

  // Mask of the vertices that take part in the running search.
  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      nmask[i] = (32'(i) < 32'(n_r));
    end
  end

  // Rows after an edge request: each endpoint gains the other one.
  always_comb begin
    for (int r = 0; r < MAX_VERTICES; r++) begin
      rows_add[r] = rows_r[r];
      if (32'(in_ch.vertex_a) == r) begin
        rows_add[r] = rows_add[r] | (MAX_VERTICES'(1) << in_ch.vertex_b);
      end
      if (32'(in_ch.vertex_b) == r) begin
        rows_add[r] = rows_add[r] | (MAX_VERTICES'(1) << in_ch.vertex_a);
      end
    end
  end

  // Degree of one vertex per cycle, self loop excluded.
  always_comb begin
    logic [MAX_VERTICES-1:0] nbrs;
    nbrs  = rows_r[d_idx_r] & nmask & ~(MAX_VERTICES'(1) << d_idx_r);
    deg_c = '0;
    for (int j = 0; j < MAX_VERTICES; j++) begin
      deg_c = deg_c + DEG_W'(nbrs[j]);
    end
  end

  assign deg_last = (32'(d_idx_r) == 32'(n_r) - 32'd1);

  // Gray-code walk: the bit that flips is the lowest set bit of the next count.
  assign cnt_inc = cnt_r + MAX_VERTICES'(1);

  always_comb begin
    flip_b = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (cnt_inc[i]) begin
        flip_b = IDX_W'(i);
      end
    end
  end

  assign flip_on   = gmask_r[flip_b];
  assign deg_f     = deg_r[flip_b];
  assign scan_last = (cnt_r == nmask);

  // Clique check and frontier of the current subset.
  mfcs_eval #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_eval (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (state_r == S_SCAN),
    .n          (n_r),
    .mask       (gmask_r),
    .rows       (rows_r),
    .dsum       (dsum_r),
    .kk         (kk_r),
    .pop        (pop_r),
    .ev_valid_r (ev_valid),
    .ev_f_r     (ev_f),
    .ev_k_r     (ev_k),
    .ev_m_r     (ev_m)
  );

  // Lexicographically earlier subsets of one size have the larger reversed mask.
  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      ev_rev[i]   = ev_m[MAX_VERTICES-1-i];
      best_rev[i] = best_m_r[MAX_VERTICES-1-i];
    end
  end

  // Larger frontier wins; a nonzero tie keeps the first in size-major, lex order.
  assign better = (ev_f > best_f_r) ||
                  ((ev_f == best_f_r) && (best_f_r != '0) &&
                   ((ev_k < best_k_r) || ((ev_k == best_k_r) && (ev_rev > best_rev))));

  // A single vertex of larger degree overrides the best clique.
  assign use_top  = SUM_W'(top_deg_r) > best_f_r;
  assign out_load = (state_r == S_FINAL) && (!out_valid_r || out_ch.ready);

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (run_acc) begin
          state_nxt = (n_sel == '0) ? S_SCAN : S_DEG;
        end
      end
      S_DEG: begin
        if (deg_last) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FINAL;
      end
      S_FINAL: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state, configuration and adjacency store.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      vcount_r <= mfcs_pkg::VCOUNT_RESET;
      rows_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        vcount_r <= cfg_wdata;
      end
      if (in_acc && (in_ch.mode == mfcs_pkg::MODE_CLEAR)) begin
        rows_r <= '0;
      end else if (in_acc && (in_ch.mode == mfcs_pkg::MODE_ADD) && add_ok) begin
        rows_r <= rows_add;
      end
    end
  end

  // Degree table, written once per vertex at the start of a search.
  always_ff @(posedge clk) begin
    if (state_r == S_DEG) begin
      deg_r[d_idx_r] <= deg_c;
    end
  end

  // Search datapath.
  always_ff @(posedge clk) begin
    if (run_acc) begin
      n_r        <= n_sel;
      d_idx_r    <= '0;
      top_deg_r  <= '0;
      top_node_r <= '0;
      cnt_r      <= '0;
      gmask_r    <= '0;
      dsum_r     <= '0;
      kk_r       <= '0;
      pop_r      <= '0;
      best_f_r   <= '0;
      best_k_r   <= '0;
      best_m_r   <= '0;
    end else begin
      // Degree counting keeps the first vertex of largest degree.
      if (state_r == S_DEG) begin
        d_idx_r <= d_idx_r + IDX_W'(1);
        if (deg_c > top_deg_r) begin
          top_deg_r  <= deg_c;
          top_node_r <= d_idx_r;
        end
      end
      // One subset step: toggle one vertex and adjust sum, size and k(k-1).
      if ((state_r == S_SCAN) && !scan_last) begin
        cnt_r           <= cnt_inc;
        gmask_r[flip_b] <= ~flip_on;
        if (flip_on) begin
          dsum_r <= dsum_r - SUM_W'(deg_f);
          kk_r   <= kk_r - ((SUM_W'(pop_r) - SUM_W'(1)) << 1);
          pop_r  <= pop_r - CNT_W'(1);
        end else begin
          dsum_r <= dsum_r + SUM_W'(deg_f);
          kk_r   <= kk_r + (SUM_W'(pop_r) << 1);
          pop_r  <= pop_r + CNT_W'(1);
        end
      end
      // Best clique update from the registered candidate.
      if (ev_valid && better) begin
        best_f_r <= ev_f;
        best_k_r <= ev_k;
        best_m_r <= ev_m;
      end
    end
  end

  assign top_mask32  = 32'(MAX_VERTICES'(1) << top_node_r);
  assign best_mask32 = 32'(best_m_r);

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (use_top) begin
        out_f_r <= mfcs_pkg::FRONTIER_W'(top_deg_r);
        out_k_r <= mfcs_pkg::SIZE_W'(1);
        out_m_r <= top_mask32[mfcs_pkg::MEMBERS_W-1:0];
      end else begin
        out_f_r <= mfcs_pkg::FRONTIER_W'(best_f_r);
        out_k_r <= mfcs_pkg::SIZE_W'(best_k_r);
        out_m_r <= best_mask32[mfcs_pkg::MEMBERS_W-1:0];
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.best_frontier = out_f_r;
  assign out_ch.best_size     = out_k_r;
  assign out_ch.best_members  = out_m_r;

endmodule

>>> src/mfcs_checker.sv
// Port-level checks on the clique search block.
module mfcs_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [mfcs_pkg::MODE_W-1:0]       in_mode,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [mfcs_pkg::FRONTIER_W-1:0]   best_frontier,
  input logic [mfcs_pkg::SIZE_W-1:0]       best_size,
  input logic [mfcs_pkg::MEMBERS_W-1:0]    best_members
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A search request keeps the block busy in the following cycle.
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_mode == mfcs_pkg::MODE_RUN) |=> !in_ready)
    else $error("request taken right after a search request");

  // An empty result carries no members and no frontier.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (best_size == '0) |-> (best_members == '0) && (best_frontier == '0))
    else $error("empty result with members or frontier");

  // A single-vertex result names exactly one vertex.
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (best_size == mfcs_pkg::SIZE_W'(1)) |-> $onehot(best_members))
    else $error("single-vertex result without exactly one member");

endmodule

bind max_frontier_clique_search mfcs_checker u_mfcs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_mode       (in_ch.mode),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .best_frontier (out_ch.best_frontier),
  .best_size     (out_ch.best_size),
  .best_members  (out_ch.best_members)
);
